// File: rtl/core/imm_pkg.sv
// Package for the interval motif matcher: field widths, configuration
// register indexes, reset values, the cell control struct and a pattern helper.
// No dependencies.
package imm_pkg;

    localparam int PITCH_W    = 7;
    localparam int IVL_W      = 8;
    localparam int TOL_W      = 7;
    localparam int PLEN_W     = 4;
    localparam int PAT_W      = 64;
    localparam int PAT_ELEMS  = 8;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH    = 2'd0,
        CFG_TOLERANCE         = 2'd1,
        CFG_PATTERN_INTERVALS = 2'd2
    } cfg_index_t;

    localparam logic [PLEN_W-1:0] PLEN_RESET = 4'd3;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 7'd1;
    localparam logic [PAT_W-1:0]  PAT_RESET  = 64'd0;

    // Per-cycle control shared by every cell of the row.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Returns signed pattern byte k; byte 0 sits in the lowest bits.
    function automatic logic signed [IVL_W-1:0] pat_byte(
        input logic [PAT_W-1:0] pat,
        input logic [2:0]       k
    );
        return pat[{k, 3'b000} +: IVL_W];
    endfunction

endpackage

// File: rtl/core/imm_cell.sv
// One window cell of the interval motif matcher: holds one interval and its
// valid bit, and compares the incoming interval against one pattern element.
// Depends on imm_pkg.
module imm_cell
    import imm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic signed [IVL_W-1:0]  shift_in,
    input  logic                     valid_in,
    input  logic signed [IVL_W-1:0]  pat_elem,
    input  logic        [TOL_W-1:0]  tolerance,
    output logic signed [IVL_W-1:0]  value,
    output logic                     valid_out,
    output logic                     hit
);

    logic signed [IVL_W-1:0] value_reg;
    logic signed [IVL_W-1:0] value_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic signed [IVL_W+1:0] diff;
    logic        [IVL_W+1:0] mag;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            value_next = shift_in;
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            value_reg <= value_next;
            valid_reg <= valid_next;
        end
    end

    // The compare looks at the value this cell takes on the current shift.
    always_comb
    begin
        diff = (IVL_W+2)'(shift_in) - (IVL_W+2)'(pat_elem);
        mag  = diff[IVL_W+1] ? (IVL_W+2)'(-diff) : (IVL_W+2)'(diff);
        hit  = valid_in && (mag <= (IVL_W+2)'(tolerance));
    end

    assign value     = value_reg;
    assign valid_out = valid_reg;

endmodule

// File: rtl/core/interval_motif_matcher.sv
// Top level of the interval motif matcher: configuration registers, pitch
// history, the row of window cells and the output register.
// Depends on imm_pkg and imm_cell.
//
// Usage: each input word carries one pitch of a single voice, in start order,
// and a new_sequence flag that marks the first note of a sequence. For every
// accepted word the block returns one output word: the interval to the
// previous pitch, window_match when the newest pattern_length intervals each
// lie within tolerance of the configured pattern (oldest interval against
// pattern element 0), and any_match, which stays set until the next
// new_sequence. The first note of a sequence gives interval 0 and no match.
//
// The window is a row of MAX_PATTERN cells; each cell holds one interval and
// a valid bit and passes both to its neighbor on every accepted word that does
// not start a sequence, while all cells compare in parallel. A result appears
// in the cycle after its input word is accepted, and one word is taken per
// cycle unless the receiver stalls. The single output register frees when
// the receiver takes the word, so in_ready stays high while out_ready is high;
// when the receiver stalls, the held result waits and in_ready drops until taken.
//
// Reset clears the history and the output valid flag and loads the
// configuration defaults (length 3, tolerance 1, all-zero pattern). The user
// must write configuration only while no word is in flight; not enforced here.
module interval_motif_matcher
    import imm_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic        [PITCH_W-1:0] pitch,
    input  logic                     new_sequence,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [IVL_W-1:0]  interval,
    output logic                     window_match,
    output logic                     any_match,
    input  logic                     cfg_we,
    input  logic      [CFG_IDX_W-1:0] cfg_index,
    input  logic        [PAT_W-1:0]  cfg_data
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int CW = (LW > PLEN_W) ? LW : PLEN_W;

    // Configuration registers.
    logic [PLEN_W-1:0] plen_reg;
    logic [TOL_W-1:0]  tol_reg;
    logic [PAT_W-1:0]  pat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= PLEN_RESET;
            tol_reg  <= TOL_RESET;
            pat_reg  <= PAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH:    plen_reg <= cfg_data[PLEN_W-1:0];
                CFG_TOLERANCE:         tol_reg  <= cfg_data[TOL_W-1:0];
                CFG_PATTERN_INTERVALS: pat_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Effective pattern length, clamped to one through MAX_PATTERN.
    logic [CW-1:0] plen_ext;
    logic [CW-1:0] len_eff;

    always_comb
    begin
        plen_ext = CW'(plen_reg);
        if (plen_ext == '0)
            len_eff = CW'(1);
        else if (plen_ext > CW'(MAX_PATTERN))
            len_eff = CW'(MAX_PATTERN);
        else
            len_eff = plen_ext;
    end

    // Handshake: the output register frees when its word is taken.
    logic in_fire;
    logic out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Interval to the previous pitch; zero on the first note of a sequence.
    logic        [PITCH_W-1:0] prev_pitch_reg;
    logic signed [IVL_W-1:0]   ivl;

    assign ivl = new_sequence ? '0
               : IVL_W'({1'b0, pitch}) - IVL_W'({1'b0, prev_pitch_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_pitch_reg <= '0;
        else if (in_fire)
            prev_pitch_reg <= pitch;
    end

    // Row of window cells. Link 0 feeds the newest interval into cell 0.
    cell_ctrl_t              ctrl;
    logic signed [IVL_W-1:0] link_value [0:MAX_PATTERN];
    logic                    link_valid [0:MAX_PATTERN];
    logic [MAX_PATTERN-1:0]  hit;
    logic [MAX_PATTERN-1:0]  active;

    assign ctrl.clear    = in_fire && new_sequence;
    assign ctrl.shift    = in_fire && !new_sequence;
    assign link_value[0] = ivl;
    assign link_valid[0] = 1'b1;

    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        localparam logic [CW-1:0] J = CW'(j);
        logic [CW-1:0]           sel;
        logic signed [IVL_W-1:0] pat_elem;

        // Cell j holds the interval j places back; it meets pattern element
        // (length - 1 - j). Elements past the stored eight read as zero.
        assign active[j] = (J < len_eff);
        assign sel       = len_eff - J - CW'(1);
        assign pat_elem  = (sel < CW'(PAT_ELEMS)) ? pat_byte(pat_reg, sel[2:0]) : '0;

        imm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .shift_in  (link_value[j]),
            .valid_in  (link_valid[j]),
            .pat_elem  (pat_elem),
            .tolerance (tol_reg),
            .value     (link_value[j+1]),
            .valid_out (link_valid[j+1]),
            .hit       (hit[j])
        );
    end

    // A window matches when the word does not start a sequence and every cell
    // inside the pattern length takes a valid interval that lies within tolerance.
    logic win;
    logic match_seen_reg;
    logic match_seen_next;

    assign win             = !new_sequence && (&(hit | ~active));
    assign match_seen_next = new_sequence ? 1'b0 : (match_seen_reg || win);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_seen_reg <= 1'b0;
        else if (in_fire)
            match_seen_reg <= match_seen_next;
    end

    // Output register.
    logic signed [IVL_W-1:0] interval_reg;
    logic                    window_match_reg;
    logic                    any_match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            interval_reg     <= ivl;
            window_match_reg <= win;
            any_match_reg    <= match_seen_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign interval     = interval_reg;
    assign window_match = window_match_reg;
    assign any_match    = any_match_reg;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    a_fresh_clean: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && new_sequence |=> interval == '0 && !window_match)
        else $error("first note of a sequence gave a nonzero interval or a match");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_match |-> any_match)
        else $error("window match without sticky match flag");
`endif

endmodule

// File: dv/tb_interval_motif_matcher.sv
// Self-checking testbench for interval_motif_matcher: a directed table of notes and
// register writes, then random melodies, all scored against a cycle-free matcher model.
// Depends on imm_pkg and the interval_motif_matcher RTL only.
module tb_interval_motif_matcher
    import imm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int WINDOW_DEPTH = 8;
    localparam int BLOCKS       = 8;
    localparam int NOTES_PER_BLOCK = 100;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 4;

    // Index 3 decodes to no register; writes to it must leave the setup alone.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

    // One expected output word.
    typedef struct packed {
        logic signed [IVL_W-1:0] ivl;
        logic                    hit;
        logic                    seen;
    } note_result_t;

    // One row of the directed plan: either a register write or a note.
    // Where "typed" is set, the expected word is written out in the row
    // instead of being taken from the model.
    typedef struct packed {
        logic                    is_write;
        logic [CFG_IDX_W-1:0]    idx;
        logic [PAT_W-1:0]        data;
        logic [PITCH_W-1:0]      note;
        logic                    fresh;
        logic                    typed;
        note_result_t            want;
    } plan_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic        [PITCH_W-1:0] pitch = '0;
    logic                      new_sequence = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [IVL_W-1:0]   interval;
    logic                      window_match;
    logic                      any_match;
    logic                      cfg_we = 1'b0;
    logic      [CFG_IDX_W-1:0] cfg_index = '0;
    logic        [PAT_W-1:0]   cfg_data = '0;

    // Model of the matcher: configuration copy and melodic history.
    logic        [PLEN_W-1:0]  pat_len  = PLEN_RESET;
    logic        [TOL_W-1:0]   pat_tol  = TOL_RESET;
    logic        [PAT_W-1:0]   pat_ivls = PAT_RESET;
    logic        [PITCH_W-1:0] last_pitch = '0;
    logic signed [IVL_W-1:0]   ivl_hist [WINDOW_DEPTH];
    int                        ivl_count = 0;
    bit                        motif_hit = 1'b0;

    // Words the model has produced that the block has not yet returned.
    note_result_t match_results [$];

    int  mismatches  = 0;
    int  words_seen  = 0;
    int  windows_hit = 0;
    int  notes_sent  = 0;
    int  setups_used = 0;
    int  send_rest_pct = 0;
    int  take_rest_pct = 0;
    bit  stall_pending = 1'b0;

    interval_motif_matcher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pitch        (pitch),
        .new_sequence (new_sequence),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interval     (interval),
        .window_match (window_match),
        .any_match    (any_match),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Effective pattern length: zero acts as one, anything above the window
    // depth acts as the full window.
    function automatic int eff_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > WINDOW_DEPTH)
            return WINDOW_DEPTH;
        return int'(pat_len);
    endfunction

    function automatic int pat_elem(input int k);
        return int'($signed(pat_ivls[8*k +: IVL_W]));
    endfunction

    // Advances the matcher model by one note and returns the word it yields.
    function automatic note_result_t step_matcher(
        input logic [PITCH_W-1:0] p,
        input logic               fresh
    );
        note_result_t r;
        int           iv;
        int           len;
        int           d;
        r = '0;
        if (fresh) begin
            foreach (ivl_hist[i])
                ivl_hist[i] = '0;
            ivl_count = 0;
            motif_hit = 1'b0;
        end
        else begin
            iv = int'(p) - int'(last_pitch);
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                ivl_hist[i] = ivl_hist[i-1];
            ivl_hist[0] = iv[IVL_W-1:0];
            if (ivl_count < WINDOW_DEPTH)
                ivl_count++;
            r.ivl = iv[IVL_W-1:0];
            len = eff_len();
            // The oldest interval of the window lines up with pattern element 0.
            if (ivl_count >= len) begin
                r.hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    d = int'(ivl_hist[len-1-i]) - pat_elem(i);
                    if (d < 0)
                        d = -d;
                    if (d > int'(pat_tol))
                        r.hit = 1'b0;
                end
            end
        end
        last_pitch = p;
        if (r.hit)
            motif_hit = 1'b1;
        r.seen = motif_hit;
        return r;
    endfunction

    function automatic plan_row_t write_row(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [PAT_W-1:0]     data
    );
        plan_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic plan_row_t note_row(
        input logic [PITCH_W-1:0] p,
        input logic               fresh
    );
        plan_row_t row;
        row = '0;
        row.note = p;
        row.fresh = fresh;
        return row;
    endfunction

    function automatic plan_row_t known_row(
        input logic [PITCH_W-1:0] p,
        input logic               fresh,
        input int                 ivl,
        input logic               hit,
        input logic               seen
    );
        plan_row_t row;
        row = note_row(p, fresh);
        row.typed = 1'b1;
        row.want.ivl = ivl[IVL_W-1:0];
        row.want.hit = hit;
        row.want.seen = seen;
        return row;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Drives one register write for a cycle and mirrors it in the model.
    // The caller lowers cfg_we once the last write of a group is done.
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0] idx,
        input logic [PAT_W-1:0]     data
    );
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            CFG_PATTERN_LENGTH:    pat_len  = data[PLEN_W-1:0];
            CFG_TOLERANCE:         pat_tol  = data[TOL_W-1:0];
            CFG_PATTERN_INTERVALS: pat_ivls = data;
            default:               ;
        endcase
        @(posedge clk);
    endtask

    // Offers one note and returns at the edge where it is taken. The
    // handshake is judged at the falling edge, when in_ready has settled.
    task automatic send_note(
        input logic [PITCH_W-1:0] p,
        input logic               fresh,
        input logic               typed,
        input note_result_t       typed_want
    );
        note_result_t r;
        while (roll(send_rest_pct)) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        pitch        <= p;
        new_sequence <= fresh;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        r = step_matcher(p, fresh);
        if (typed)
            r = typed_want;
        match_results = {match_results, r};
        notes_sent++;
        @(posedge clk);
    endtask

    // Stops offering and waits until every predicted word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (match_results.size() != 0)
            @(posedge clk);
    endtask

    // Picks and writes a fresh setup for one random block. The first few
    // blocks pin the extremes of length and tolerance.
    task automatic setup_block(input int b);
        logic [PAT_W-1:0] d;
        int               len;
        int               tol;
        len = (b == 0) ? WINDOW_DEPTH : (b == 1) ? 1 : (b == 2) ? 0 :
              (b == 3) ? 15 : $urandom_range(15);
        tol = (b == 0) ? 0 : (b == 1) ? 127 :
              (b == 5) ? $urandom_range(127) : $urandom_range(3);
        drain();
        // Upper bits carry noise; the block must keep only the field width.
        d = {$urandom, $urandom};
        d[PLEN_W-1:0] = len[PLEN_W-1:0];
        write_reg(CFG_PATTERN_LENGTH, d);
        d = {$urandom, $urandom};
        d[TOL_W-1:0] = tol[TOL_W-1:0];
        write_reg(CFG_TOLERANCE, d);
        if (b == 1 || b == 4) begin
            d = {$urandom, $urandom};
        end
        else begin
            // Small steps keep the generated melodies inside the pitch range.
            for (int k = 0; k < PAT_ELEMS; k++)
                d[8*k +: IVL_W] = IVL_W'(int'($urandom_range(24)) - 12);
        end
        write_reg(CFG_PATTERN_INTERVALS, d);
        write_reg(CFG_NO_REG, {$urandom, $urandom});
        cfg_we <= 1'b0;
        setups_used++;
    endtask

    // Plays one block of random notes. Most notes follow the configured
    // pattern with a small jitter so that windows match often; the rest are
    // random pitches and new sequences that break the motif up.
    task automatic play_block();
        logic [PITCH_W-1:0] p;
        logic               fresh;
        int                 gen_last;
        int                 motif_pos;
        int                 jit;
        int                 target;
        int                 pick;
        note_result_t       none;
        none = '0;
        gen_last = int'(last_pitch);
        motif_pos = 0;
        for (int n = 0; n < NOTES_PER_BLOCK; n++) begin
            pick = $urandom_range(99);
            fresh = 1'b0;
            if (n == 0 || pick < 6) begin
                fresh = 1'b1;
                p = PITCH_W'($urandom_range(127));
                motif_pos = 0;
            end
            else if (pick < 18) begin
                p = PITCH_W'($urandom_range(127));
            end
            else begin
                jit = (pat_tol < 3) ? int'(pat_tol) + 1 : 3;
                target = gen_last + pat_elem(motif_pos) + int'($urandom_range(2 * jit)) - jit;
                p = (target < 0 || target > 127) ? PITCH_W'($urandom_range(127))
                                                 : PITCH_W'(target);
                motif_pos = (motif_pos + 1) % eff_len();
            end
            gen_last = int'(p);
            send_note(p, fresh, 1'b0, none);
        end
    endtask

    // Receiver: stalls at random at the rate of the current phase, and once
    // holds off for a long stretch so the output register fills and the
    // block pushes back on its input.
    initial
    begin
        int hold_cycles;
        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (stall_pending) begin
                stall_pending = 1'b0;
                hold_cycles = LONG_HOLD;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= !roll(take_rest_pct);
            end
        end
    end

    // Output checker: a word is taken at the rising edge after a falling
    // edge that sees out_valid and out_ready high, so it is scored there.
    always @(negedge clk)
    begin : score_words
        note_result_t want;
        if (rst_n && out_valid && out_ready) begin
            words_seen++;
            if (window_match === 1'b1)
                windows_hit++;
            if (match_results.size() == 0) begin
                $error("output word with no note pending: interval %0d", interval);
                mismatches++;
            end
            else begin
                want = match_results.pop_front();
                if (interval !== want.ivl) begin
                    $error("interval: expected %0d, got %0d", want.ivl, interval);
                    mismatches++;
                end
                if (window_match !== want.hit) begin
                    $error("window_match: expected %0b, got %0b", want.hit, window_match);
                    mismatches++;
                end
                if (any_match !== want.seen) begin
                    $error("any_match: expected %0b, got %0b", want.seen, any_match);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d words still pending", match_results.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        plan_row_t plan [$];
        plan_row_t row;

        foreach (ivl_hist[i])
            ivl_hist[i] = '0;

        // Directed plan. The reset setup is length 3, tolerance 1 and an
        // all-zero pattern.
        // A note with no new-sequence mark after reset continues from pitch 0.
        plan = {plan, known_row(7'd127, 1'b0, 127, 1'b0, 1'b0)};
        plan = {plan, known_row(7'd0,   1'b0, -127, 1'b0, 1'b0)};
        // A new sequence gives interval 0 and clears the history.
        plan = {plan, known_row(7'd0,   1'b1, 0, 1'b0, 1'b0)};
        plan = {plan, note_row(7'd0, 1'b0)};
        plan = {plan, note_row(7'd1, 1'b0)};
        // Window 0, 1, 0 lies within one of the zero pattern.
        plan = {plan, known_row(7'd1,   1'b0, 0, 1'b1, 1'b1)};
        plan = {plan, note_row(7'd3, 1'b0)};
        // The sticky flag drops at the next sequence.
        plan = {plan, known_row(7'd64,  1'b1, 0, 1'b0, 1'b0)};
        // Length 0 acts as 1; tolerance 0; pattern element 0 is +5. The
        // writes carry all-ones upper bits, and a write to the unused index
        // must change nothing.
        plan = {plan, write_row(CFG_PATTERN_LENGTH,    64'hFFFF_FFFF_FFFF_FFF0)};
        plan = {plan, write_row(CFG_TOLERANCE,         64'hFFFF_FFFF_FFFF_FF80)};
        plan = {plan, write_row(CFG_PATTERN_INTERVALS, 64'h0000_0000_0000_0005)};
        plan = {plan, write_row(CFG_NO_REG,            64'hFFFF_FFFF_FFFF_FFFF)};
        plan = {plan, note_row(7'd10, 1'b1)};
        plan = {plan, known_row(7'd15, 1'b0, 5, 1'b1, 1'b1)};
        plan = {plan, known_row(7'd20, 1'b0, 5, 1'b1, 1'b1)};
        plan = {plan, known_row(7'd19, 1'b0, -1, 1'b0, 1'b1)};
        // Length 15 acts as the full window, widest tolerance, every element
        // at the most negative interval: any falling step matches.
        plan = {plan, write_row(CFG_PATTERN_LENGTH,    64'h0000_0000_0000_000F)};
        plan = {plan, write_row(CFG_TOLERANCE,         64'h0000_0000_0000_007F)};
        plan = {plan, write_row(CFG_PATTERN_INTERVALS, 64'h8080_8080_8080_8080)};
        plan = {plan, note_row(7'd127, 1'b1)};
        // Too few intervals through the seventh falling step.
        plan = {plan, note_row(7'd120, 1'b0)};
        plan = {plan, note_row(7'd110, 1'b0)};
        plan = {plan, note_row(7'd100, 1'b0)};
        plan = {plan, note_row(7'd90,  1'b0)};
        plan = {plan, note_row(7'd80,  1'b0)};
        plan = {plan, note_row(7'd70,  1'b0)};
        plan = {plan, note_row(7'd60,  1'b0)};
        // The eighth falling step fills the window.
        plan = {plan, note_row(7'd0,   1'b0)};
        // A rise of 127 sits 255 away from the pattern element.
        plan = {plan, note_row(7'd127, 1'b0)};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with both sides at the first phase rates.
        send_rest_pct = 37;
        take_rest_pct = 51;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) begin
                drain();
                write_reg(row.idx, row.data);
            end
            else begin
                if (cfg_we)
                    cfg_we <= 1'b0;
                send_note(row.note, row.fresh, row.typed, row.want);
            end
        end

        // Random blocks: receiver rests more than the sender at first, then
        // the other way round, then neither rests. The long receiver hold
        // falls at the start of the no-rest phase, where the sender offers
        // a note on every cycle.
        for (int b = 0; b < BLOCKS; b++) begin
            setup_block(b);
            if (b < 3) begin
                send_rest_pct = 37;
                take_rest_pct = 51;
            end
            else if (b < 6) begin
                send_rest_pct = 51;
                take_rest_pct = 37;
            end
            else begin
                send_rest_pct = 0;
                take_rest_pct = 0;
            end
            if (b == 6)
                stall_pending = 1'b1;
            play_block();
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (match_results.size() != 0) begin
            $error("%0d predicted words never arrived", match_results.size());
            mismatches++;
        end

        $display("Sent %0d notes under %0d random setups plus the directed plan;",
                 notes_sent, setups_used);
        $display("checked %0d output words, %0d of them window matches.",
                 words_seen, windows_hit);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
